// ===== hdl/delayed_difference_resampler_assert.svh =====
// Assertion macros for the delayed difference resampler.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DELAYED_DIFFERENCE_RESAMPLER_ASSERT_SVH
`define DELAYED_DIFFERENCE_RESAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ddr_pkg.sv =====
// Shared types and constants of the delayed difference resampler.
// No dependencies; used by ddr_interp and the top level.
`default_nettype none

package ddr_pkg;

	// Register word indexes on the configuration port (paddr[2]).
	localparam logic REG_DELAY     = 1'b0;
	localparam logic REG_GRID_STEP = 1'b1;

	// Quotient bits resolved by the divider; larger quotients saturate.
	localparam int QUOT_BITS = 18;

	// Request from the control sequencer to the interpolation unit.
	typedef struct packed {
		logic               start;
		logic signed [16:0] dv;   // newest value minus previous value
		logic signed [32:0] dt;   // grid time minus previous sample time
		logic        [31:0] gap;  // newest time minus previous time, positive
		logic signed [15:0] pv;   // previous value
	} ddr_interp_req_t;

	// Response of the interpolation unit.
	typedef struct packed {
		logic               done;
		logic signed [15:0] g;
	} ddr_interp_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/delayed_difference_resampler.sv =====
// Delayed difference resampler: one sample in at a time, grid points out.
// An interpolated grid point passes through the interpolation unit (multiply, then the divider),
// while a point taking the newest value skips it; receiver stalls hold a point until it is taken.
// Reset is asynchronous and active low; it clears the control state and counters.
// Depends on ddr_pkg, ddr_hist_ram, ddr_interp and the assertion header.
`default_nettype none

`include "delayed_difference_resampler_assert.svh"

module delayed_difference_resampler #(
	parameter int MAX_DELAY = 256,
	parameter int MAX_BURST = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Sample input
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // [15:0] sample_value, [47:16] sample_time
	input  wire         s_tlast,   // end_of_waveform
	// Result output
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [16:0] difference, [32:17] grid_index, zero pad
	output logic        m_tuser,   // [0] zero_gap
	output logic        m_tlast    // last
);

	localparam int HPW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int CW   = ((HPW > 8) ? HPW : 8) + 1;
	localparam int NW   = $clog2(MAX_BURST + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_NEXT   = 3'd1;
	localparam logic [2:0] ST_CHK    = 3'd2;
	localparam logic [2:0] ST_INTERP = 3'd3;
	localparam logic [2:0] ST_REL    = 3'd4;
	localparam logic [2:0] ST_END    = 3'd5;

	logic [2:0]         state_q;
	logic [7:0]         delay_q;
	logic [15:0]        grid_step_q;

	logic signed [15:0] v_q;
	logic [31:0]        t_q;
	logic               eow_q;
	logic               had_q;
	logic [15:0]        step_q;
	logic [31:0]        pt_q;
	logic signed [15:0] pv_q;
	logic [15:0]        ngp_q;
	logic [15:0]        sr_q;
	logic [HPW-1:0]     hp_q;
	logic [NW-1:0]      n_q;
	logic               phase_b_q;
	logic [31:0]        tj_q;
	logic signed [15:0] g_q;
	logic               zg_q;

	logic               m_tvalid_q;
	logic signed [16:0] diff_q;
	logic [15:0]        gidx_q;
	logic               zg_out_q;
	logic               last_q;

	logic               cfg_wr;
	logic               in_fire;
	logic               loop_more;
	logic               rel_fire;
	logic               rel_last;
	logic               use_hist;
	logic [CW-1:0]      d_eff;
	logic [CW-1:0]      hp_ext;
	logic [HPW-1:0]     rd_addr;
	logic signed [15:0] hist_rdata;
	logic signed [16:0] diff_val;
	logic               ram_re;

	ddr_pkg::ddr_interp_req_t interp_req;
	ddr_pkg::ddr_interp_rsp_t interp_rsp;

	// Configuration registers; byte address bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= 8'd0;
			grid_step_q <= 16'd1;
		end else if (cfg_wr) begin
			case (paddr[2])
				ddr_pkg::REG_DELAY:     delay_q     <= pwdata[7:0];
				ddr_pkg::REG_GRID_STEP: grid_step_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ddr_pkg::REG_DELAY:     prdata = {24'd0, delay_q};
			ddr_pkg::REG_GRID_STEP: prdata = {16'd0, grid_step_q};
			default:                prdata = 32'd0;
		endcase
	end

	// Handshakes and loop control.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid & s_tready;
	assign loop_more = (n_q < NW'(MAX_BURST)) && (ngp_q < sr_q);
	assign rel_fire  = (state_q == ST_REL) && (!m_tvalid_q || m_tready);
	assign rel_last  = eow_q && ((n_q == NW'(MAX_BURST - 1)) ||
		(({1'b0, ngp_q} + 17'd1) == {1'b0, sr_q}));

	// History read address: the entry written delay grid points earlier.
	assign d_eff  = (CW'(delay_q) >= CW'(MAX_DELAY)) ? CW'(MAX_DELAY - 1) : CW'(delay_q);
	assign hp_ext = CW'(hp_q);
	always_comb begin
		if (hp_ext >= d_eff) begin
			rd_addr = HPW'(hp_ext - d_eff);
		end else begin
			rd_addr = HPW'(hp_ext + CW'(MAX_DELAY) - d_eff);
		end
	end

	assign ram_re = (state_q == ST_NEXT) && loop_more;

	ddr_hist_ram #(
		.DEPTH (MAX_DELAY),
		.AW    (HPW)
	) u_hist (
		.clk   (clk),
		.we    (rel_fire),
		.waddr (hp_q),
		.wdata (g_q),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (hist_rdata)
	);

	// Difference against the history; zero for the first delay+1 points, for zero-gap points and for a delay of zero.
	assign use_hist = ({1'b0, ngp_q} > 17'(d_eff)) && !zg_q && (d_eff != CW'(0));
	assign diff_val = use_hist ? (17'(g_q) - 17'(hist_rdata)) : 17'sd0;

	// Operands of the interpolation, valid while checking a bracketed point.
	always_comb begin
		interp_req.start = (state_q == ST_CHK) && !phase_b_q && (tj_q < t_q) &&
			had_q && (t_q > pt_q);
		interp_req.dv    = 17'(v_q) - 17'(pv_q);
		interp_req.dt    = $signed({1'b0, tj_q}) - $signed({1'b0, pt_q});
		interp_req.gap   = t_q - pt_q;
		interp_req.pv    = pv_q;
	end

	ddr_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (interp_req),
		.rsp    (interp_rsp)
	);

	// Control sequencer and waveform state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pt_q      <= 32'd0;
			pv_q      <= 16'sd0;
			ngp_q     <= 16'd0;
			sr_q      <= 16'd0;
			hp_q      <= '0;
			n_q       <= '0;
			phase_b_q <= 1'b0;
			eow_q     <= 1'b0;
			had_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						eow_q     <= s_tlast;
						had_q     <= (sr_q != 16'd0);
						if (sr_q != 16'hFFFF) begin
							sr_q <= sr_q + 16'd1;
						end
						n_q       <= '0;
						phase_b_q <= 1'b0;
						state_q   <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					state_q <= loop_more ? ST_CHK : ST_END;
				end
				ST_CHK: begin
					if (phase_b_q) begin
						state_q <= ST_REL;
					end else if (!(tj_q < t_q)) begin
						if (eow_q) begin
							phase_b_q <= 1'b1;
							state_q   <= ST_REL;
						end else begin
							state_q <= ST_END;
						end
					end else if (interp_req.start) begin
						state_q <= ST_INTERP;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_INTERP: begin
					if (interp_rsp.done) begin
						state_q <= ST_REL;
					end
				end
				ST_REL: begin
					if (rel_fire) begin
						ngp_q   <= ngp_q + 16'd1;
						hp_q    <= (hp_q == HPW'(MAX_DELAY - 1)) ? '0 : hp_q + HPW'(1);
						n_q     <= n_q + NW'(1);
						state_q <= ST_NEXT;
					end
				end
				ST_END: begin
					if (eow_q) begin
						pt_q  <= 32'd0;
						pv_q  <= 16'sd0;
						ngp_q <= 16'd0;
						sr_q  <= 16'd0;
						hp_q  <= '0;
					end else begin
						pt_q <= t_q;
						pv_q <= v_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload, grid time and the value of the current point.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_q    <= $signed(s_tdata[15:0]);
			t_q    <= s_tdata[47:16];
			step_q <= (grid_step_q == 16'd0) ? 16'd1 : grid_step_q;
		end
		if (state_q == ST_NEXT) begin
			tj_q <= 32'(ngp_q) * 32'(step_q);
		end
		if (state_q == ST_CHK) begin
			g_q  <= v_q;
			zg_q <= !phase_b_q && (tj_q < t_q) && had_q && !(t_q > pt_q);
		end
		if ((state_q == ST_INTERP) && interp_rsp.done) begin
			g_q  <= interp_rsp.g;
			zg_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rel_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rel_fire) begin
			diff_q   <= diff_val;
			gidx_q   <= ngp_q;
			zg_out_q <= zg_q;
			last_q   <= rel_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, gidx_q, diff_q};
	assign m_tuser  = zg_out_q;
	assign m_tlast  = last_q;

	// A released point is always below the number of samples received.
	`DDR_ASSERT_SAME(a_rel_in_range, rel_fire, ngp_q < sr_q, "grid point released too early")
	// The final word of a waveform ends the burst.
	`DDR_ASSERT_NEXT(a_last_ends_burst, rel_fire && rel_last, !loop_more, "burst continues after last")
	// The end of a waveform clears the counters.
	`DDR_ASSERT_NEXT(a_eow_clears, (state_q == ST_END) && eow_q, (ngp_q == 16'd0) && (sr_q == 16'd0), "state not cleared at end of waveform")

endmodule

`default_nettype wire

// ===== hdl/ddr_hist_ram.sv =====
// History memory of resampled grid values: one write port, one read port.
// Synchronous read with registered data; no package dependencies.
`default_nettype none

module ddr_hist_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire        [AW-1:0]     waddr,
	input  wire signed [15:0]       wdata,
	input  wire                     re,
	input  wire        [AW-1:0]     raddr,
	output logic signed [15:0]      rdata
);

	logic signed [15:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data is registered on a read enable.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ddr_interp.sv =====
// Interpolation unit: split multiply, then an iterative restoring divider.
// Depends on ddr_pkg for the request and response types.
`default_nettype none

module ddr_interp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  ddr_pkg::ddr_interp_req_t   req,
	output ddr_pkg::ddr_interp_rsp_t   rsp
);

	localparam logic [2:0] I_IDLE = 3'd0;
	localparam logic [2:0] I_PLO  = 3'd1;
	localparam logic [2:0] I_PHI  = 3'd2;
	localparam logic [2:0] I_SUM  = 3'd3;
	localparam logic [2:0] I_ABS  = 3'd4;
	localparam logic [2:0] I_DIVI = 3'd5;
	localparam logic [2:0] I_DIV  = 3'd6;
	localparam logic [2:0] I_FIN  = 3'd7;

	localparam int QB = ddr_pkg::QUOT_BITS;
	localparam int CNTW = $clog2(QB + 1);

	logic [2:0]          state_q;
	logic signed [16:0]  dv_q;
	logic signed [32:0]  dt_q;
	logic        [31:0]  gap_q;
	logic signed [15:0]  pv_q;
	logic signed [33:0]  plo_q;
	logic signed [33:0]  phi_q;
	logic signed [49:0]  num_q;
	logic        [49:0]  mag_q;
	logic                neg_q;
	logic        [31:0]  rem_q;
	logic        [QB-1:0] low_q;
	logic        [QB:0]  quot_q;
	logic        [CNTW-1:0] cnt_q;

	logic        [32:0]  trial;
	logic        [32:0]  trial_diff;
	logic signed [QB+1:0] quot_signed;
	logic signed [QB+2:0] sum;
	logic signed [15:0]  g_sat;

	// One divider step: shift in the next dividend bit and try the subtraction.
	assign trial      = {rem_q, low_q[QB-1]};
	assign trial_diff = trial - {1'b0, gap_q};

	// Signed quotient, added to the previous value and saturated to 16 bits.
	always_comb begin
		quot_signed = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
		sum = (QB+3)'(pv_q) + (QB+3)'(quot_signed);
		if (sum > (QB+3)'(32767)) begin
			g_sat = 16'sh7FFF;
		end else if (sum < -(QB+3)'(32768)) begin
			g_sat = -16'sh8000;
		end else begin
			g_sat = sum[15:0];
		end
	end

	assign rsp.done = (state_q == I_FIN);
	assign rsp.g    = g_sat;

	// Sequencer of the multiply and divide steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
		end else begin
			case (state_q)
				I_IDLE: begin
					if (req.start) begin
						state_q <= I_PLO;
					end
				end
				I_PLO:  state_q <= I_PHI;
				I_PHI:  state_q <= I_SUM;
				I_SUM:  state_q <= I_ABS;
				I_ABS:  state_q <= I_DIVI;
				I_DIVI: begin
					if (mag_q >= {gap_q, QB'(0)}) begin
						state_q <= I_FIN;
					end else begin
						state_q <= I_DIV;
					end
				end
				I_DIV: begin
					if (cnt_q == CNTW'(1)) begin
						state_q <= I_FIN;
					end
				end
				I_FIN:  state_q <= I_IDLE;
				default: state_q <= I_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			I_IDLE: begin
				if (req.start) begin
					dv_q  <= req.dv;
					dt_q  <= req.dt;
					gap_q <= req.gap;
					pv_q  <= req.pv;
				end
			end
			I_PLO: begin
				// Low half of the time offset, taken as unsigned.
				plo_q <= dv_q * $signed({1'b0, dt_q[15:0]});
			end
			I_PHI: begin
				phi_q <= dv_q * $signed(dt_q[32:16]);
			end
			I_SUM: begin
				num_q <= (50'(phi_q) <<< 16) + 50'(plo_q);
			end
			I_ABS: begin
				neg_q <= num_q[49];
				mag_q <= num_q[49] ? 50'(-num_q) : 50'(num_q);
			end
			I_DIVI: begin
				// A quotient that cannot fit saturates the result anyway.
				quot_q <= {1'b1, QB'(0)};
				rem_q  <= mag_q[49:QB];
				low_q  <= mag_q[QB-1:0];
				cnt_q  <= CNTW'(QB);
			end
			I_DIV: begin
				if (!trial_diff[32]) begin
					rem_q  <= trial_diff[31:0];
					quot_q <= {quot_q[QB-1:0], 1'b1} & {1'b0, {QB{1'b1}}};
				end else begin
					rem_q  <= trial[31:0];
					quot_q <= {quot_q[QB-1:0], 1'b0} & {1'b0, {QB{1'b1}}};
				end
				low_q <= {low_q[QB-2:0], 1'b0};
				cnt_q <= cnt_q - CNTW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench of the delayed difference resampler: streams timestamped sample words in,
// predicts every grid-point result word and checks the results in arrival order.
// Depends on ddr_pkg and the delayed_difference_resampler top level.

module testbench;

	localparam int HISTORY_DEPTH  = 256;
	localparam int BURST_LIMIT    = 64;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [2:0] ADDR_DELAY     = {ddr_pkg::REG_DELAY, 2'b00};
	localparam logic [2:0] ADDR_GRID_STEP = {ddr_pkg::REG_GRID_STEP, 2'b00};

	// One expected result word.
	typedef struct packed {
		logic signed [16:0] difference;
		logic        [15:0] grid_index;
		logic               zero_gap;
		logic               is_last;
	} grid_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // [15:0] sample_value, [47:16] sample_time
	logic        s_tlast  = 1'b0; // end_of_waveform
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [16:0] difference, [32:17] grid_index, zero pad
	logic        m_tuser;         // [0] zero_gap
	logic        m_tlast;         // last

	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct  = 0;
	int unsigned mismatch_count  = 0;
	int unsigned quiet_cycles    = 0;

	// Predicted resampler state and configuration.
	logic        [7:0]  cfg_delay;
	logic        [15:0] cfg_step;
	logic signed [15:0] hist_g [HISTORY_DEPTH];
	logic        [7:0]  hist_ptr;
	logic        [31:0] prev_time;
	logic signed [15:0] prev_value;
	logic        [15:0] next_point;
	logic        [15:0] samples_seen;

	grid_result_t grid_results_q[$];

	delayed_difference_resampler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Counts a mismatch and tells whether it is still worth a report line.
	function automatic bit count_mismatch();
		mismatch_count++;
		return mismatch_count <= REPORT_LIMIT;
	endfunction

	function automatic logic signed [15:0] saturate16(input longint x);
		if (x > 32767)
			return 16'sh7FFF;
		if (x < -32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	// End of a waveform wipes everything but the registers.
	function automatic void clear_waveform();
		for (int i = 0; i < HISTORY_DEPTH; i++)
			hist_g[i] = '0;
		hist_ptr     = '0;
		prev_time    = '0;
		prev_value   = '0;
		next_point   = '0;
		samples_seen = '0;
	endfunction

	// Stores g of the next grid point and queues its delayed difference.
	function automatic void emit_grid_point(input logic signed [15:0] g, input logic zg);
		logic        [7:0]  back_ptr;
		logic signed [16:0] diff;
		grid_result_t       res;
		hist_g[hist_ptr] = g;
		back_ptr = hist_ptr - cfg_delay;
		diff = '0;
		if (next_point > {8'd0, cfg_delay} && !zg)
			diff = g - hist_g[back_ptr];
		res.difference = diff;
		res.grid_index = next_point;
		res.zero_gap   = zg;
		res.is_last    = 1'b0;
		grid_results_q.push_back(res);
		hist_ptr++;
		next_point++;
	endfunction

	// Works out every grid point that one accepted sample word releases.
	function automatic void resample_sample(input logic signed [15:0] value,
			input logic [31:0] stamp, input logic eow);
		logic               had;
		logic        [31:0] spacing;
		logic        [31:0] tj;
		logic signed [15:0] g;
		logic               zg;
		longint             gap;
		longint             num;
		int                 emitted;
		grid_result_t       tail;
		had = (samples_seen != 16'd0);
		spacing = (cfg_step == 16'd0) ? 32'd1 : {16'd0, cfg_step};
		emitted = 0;
		if (samples_seen != 16'hFFFF)
			samples_seen++;

		// Points bracketed by the newest sample, interpolated from the previous one.
		while (emitted < BURST_LIMIT && next_point < samples_seen) begin
			tj = {16'd0, next_point} * spacing;
			if (tj >= stamp)
				break;
			g  = value;
			zg = 1'b0;
			if (had) begin
				gap = longint'({32'd0, stamp}) - longint'({32'd0, prev_time});
				if (gap <= 0) begin
					zg = 1'b1;
				end else begin
					num = (longint'(value) - longint'(prev_value)) *
						(longint'({32'd0, tj}) - longint'({32'd0, prev_time}));
					g = saturate16(longint'(prev_value) + num / gap);
				end
			end
			emit_grid_point(g, zg);
			emitted++;
		end

		// The last sample flushes the waiting points with its own value.
		if (eow) begin
			while (emitted < BURST_LIMIT && next_point < samples_seen) begin
				emit_grid_point(value, 1'b0);
				emitted++;
			end
			if (emitted > 0) begin
				tail = grid_results_q.pop_back();
				tail.is_last = 1'b1;
				grid_results_q.push_back(tail);
			end
			clear_waveform();
		end else begin
			prev_time  = stamp;
			prev_value = value;
		end
	endfunction

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk)
		m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);

	// Each result word is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		grid_result_t got;
		grid_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.difference = m_tdata[16:0];
			got.grid_index = m_tdata[32:17];
			got.zero_gap   = m_tuser;
			got.is_last    = m_tlast;
			if (grid_results_q.size() == 0) begin
				if (count_mismatch())
					$display("Unexpected result word: diff=%0d index=%0d zero_gap=%0b last=%0b",
						got.difference, got.grid_index, got.zero_gap, got.is_last);
			end else begin
				want = grid_results_q.pop_front();
				if (got.difference !== want.difference || got.grid_index !== want.grid_index ||
						got.zero_gap !== want.zero_gap || got.is_last !== want.is_last) begin
					if (count_mismatch())
						$display("Grid point %0d: expected diff=%0d index=%0d zg=%0b last=%0b, %s",
							want.grid_index, want.difference, want.grid_index,
							want.zero_gap, want.is_last, $sformatf(
							"got diff=%0d index=%0d zg=%0b last=%0b", got.difference,
							got.grid_index, got.zero_gap, got.is_last));
				end
			end
		end
	end

	// Ends a run in which nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// A setup phase, then an access phase held until pready, on the configuration port.
	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [2:0] addr, input logic [31:0] want,
			input logic [31:0] mask);
		logic [31:0] rdata;
		apb_access(1'b0, addr, '0, rdata);
		if ((rdata & mask) !== want)
			if (count_mismatch())
				$display("Register at %0d: expected %0d, read %0d", addr, want, rdata & mask);
	endtask

	// Writes both registers, mirrors them in the predictor and reads them back.
	task automatic set_config(input logic [7:0] dly, input logic [15:0] stp);
		logic [31:0] rdata;
		apb_access(1'b1, ADDR_DELAY, {24'd0, dly}, rdata);
		cfg_delay = dly;
		apb_access(1'b1, ADDR_GRID_STEP, {16'd0, stp}, rdata);
		cfg_step = stp;
		check_register(ADDR_DELAY, {24'd0, dly}, 32'h0000_00FF);
		check_register(ADDR_GRID_STEP, {16'd0, stp}, 32'h0000_FFFF);
	endtask

	// Offers one sample word, with random idle cycles ahead of it.
	task automatic send_sample(input logic signed [15:0] value, input logic [31:0] stamp,
			input logic eow);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stamp, value};
		s_tlast  <= eow;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		resample_sample(value, stamp, eow);
	endtask

	// Lets every predicted word arrive, then gives the block time to go idle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (grid_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// A waveform of increasing times with some repeated and backward stamps.
	task automatic send_random_waveform(input int unsigned len);
		logic        [31:0] stamp;
		logic signed [15:0] value;
		int unsigned        span;
		int unsigned        roll;
		int                 walk;
		span  = (cfg_step == 16'd0) ? 1 : cfg_step;
		stamp = $urandom_range(1, 0) ? $urandom : $urandom_range(2 * span, 0);
		value = 16'($urandom);
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99, 0);
			if (roll >= 8)
				stamp = stamp + $urandom_range(3 * span, 1);
			else if (roll >= 5)
				stamp = stamp - $urandom_range(span, 1);
			if ($urandom_range(9, 0) < 3) begin
				value = 16'($urandom);
			end else begin
				walk = int'(value) + int'($urandom_range(2000, 0)) - 1000;
				if (walk > 32767)
					walk = 32767;
				if (walk < -32768)
					walk = -32768;
				value = walk[15:0];
			end
			send_sample(value, stamp, k == len - 1);
		end
	endtask

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [7:0] dly, input logic [15:0] stp, input int unsigned item_goal);
		int unsigned sent;
		int unsigned len;
		set_config(dly, stp);
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		sent = 0;
		while (sent < item_goal) begin
			len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 21) : $urandom_range(20, 1);
			send_random_waveform(len);
			sent += len;
		end
		wait_idle();
	endtask

	task automatic test_register_reset();
		check_register(ADDR_DELAY, 32'd0, 32'h0000_00FF);
		check_register(ADDR_GRID_STEP, 32'd1, 32'h0000_FFFF);
	endtask

	task automatic test_directed_cases();
		// Grid points before the first sample, a saturated lagging point, a zero
		// gap, a backward stamp that releases nothing, and an end-of-waveform flush.
		set_config(8'd2, 16'd10);
		send_sample(16'h7FFF, 32'd25, 1'b0);
		send_sample(16'h8000, 32'd40, 1'b0);
		send_sample(16'h0064, 32'd40, 1'b0);
		send_sample(16'hFFFB, 32'd30, 1'b0);
		send_sample(16'h03E8, 32'd70, 1'b0);
		send_sample(16'hFC18, 32'd95, 1'b0);
		send_sample(16'h0000, 32'd200, 1'b1);
		wait_idle();

		// A zero grid step behaves as one; time stamps at both ends of their range.
		set_config(8'd0, 16'd0);
		send_sample(16'hFFFF, 32'h0000_0000, 1'b0);
		send_sample(16'h0005, 32'hFFFF_FFFF, 1'b0);
		send_sample(16'h8000, 32'hFFFF_FFFF, 1'b1);
		wait_idle();

		// Largest delay and grid step.
		set_config(8'd255, 16'd65535);
		send_sample(16'h04D2, 32'hFFFF_FFFF, 1'b0);
		send_sample(16'hFFF9, 32'd5, 1'b1);
		wait_idle();
	endtask

	task automatic test_burst_limit();
		// Samples packed below the second grid point leave 65 points waiting; the
		// final sample releases a full burst and the rest is dropped.
		set_config(8'd40, 16'd65535);
		for (int k = 1; k <= 66; k++)
			send_sample(16'($urandom), k, 1'b0);
		send_sample(16'($urandom), 32'hFFFF_FFF0, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_phases();
		run_random_phase(0, 0, 8'd1, 16'd7, 20);
		run_random_phase(45, 0, 8'($urandom_range(8, 0)), 16'($urandom_range(300, 1)), 20);
		run_random_phase(0, 45, 8'd3, 16'd65535, 20);
		run_random_phase(30, 30, 8'($urandom_range(12, 0)), 16'($urandom_range(50, 1)), 20);
	endtask

	initial begin
		cfg_delay = 8'd0;
		cfg_step  = 16'd1;
		clear_waveform();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_cases();
		test_burst_limit();
		test_random_phases();
		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
